FILE: src/osam_pkg.sv
`default_nettype none

package osam_pkg;

    // Register indexes on the configuration port (byte address = 4 * index)
    typedef enum logic [2:0] {
        REG_SPEED_LIMIT      = 3'd0,
        REG_TIME_THRESHOLD   = 3'd1,
        REG_EARLY_WARN_DELTA = 3'd2,
        REG_REPORT_INTERVAL  = 3'd3,
        REG_AREA_TYPE        = 3'd4,
        REG_AREA_ID          = 3'd5
    } reg_idx_t;

    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    // Reset values of the configuration registers
    localparam logic [7:0]  SPEED_LIMIT_RST      = 8'd0;
    localparam logic [15:0] TIME_THRESHOLD_RST   = 16'd10;
    localparam logic [15:0] EARLY_WARN_DELTA_RST = 16'd100;
    localparam logic [15:0] REPORT_INTERVAL_RST  = 16'd0;
    localparam logic [7:0]  AREA_TYPE_RST        = 8'd0;
    localparam logic [31:0] AREA_ID_RST          = 32'd0;

    // Divide by ten as multiply and shift; exact over the full input range
    localparam logic [31:0] DIV10_MUL_16   = 32'd52429;
    localparam int unsigned DIV10_SHIFT_16 = 19;
    localparam logic [15:0] DIV10_MUL_8    = 16'd205;
    localparam int unsigned DIV10_SHIFT_8  = 11;

    localparam logic [6:0] ANN_LEVEL_MIN = 7'd30;
    localparam logic [6:0] ANN_LEVEL_MAX = 7'd120;

    typedef struct packed {
        logic [7:0]  vehicle_speed;
        logic [31:0] now_seconds;
    } sample_t;

    typedef struct packed {
        logic        overspeed_alarm;
        logic        prewarn_alarm;
        logic        announce_overspeed;
        logic        announce_prewarn;
        logic [6:0]  announced_limit;
        logic        report_valid;
        logic [7:0]  report_area_type;
        logic [31:0] report_area_id;
    } result_t;

    // Configuration as seen by the evaluation logic
    typedef struct packed {
        logic [7:0]  speed_limit;
        logic [15:0] time_threshold;
        logic [15:0] report_interval;
        logic [7:0]  area_type;
        logic [31:0] area_id;
        logic [7:0]  prewarn_level;
        logic [6:0]  ann_level;
    } cfg_t;

    typedef struct packed {
        logic [31:0] over_start_time;
        logic        over_start_valid;
        logic [31:0] release_start_time;
        logic        release_start_valid;
        logic [31:0] last_report_time;
        logic        alarm_flag;
        logic        prewarn_flag;
    } state_t;

endpackage

`default_nettype wire

FILE: src/overspeed_alarm_monitor.sv
// Overspeed alarm monitor.
// Input channel in_valid/in_ready/in_data carries one request per speed sample
// (vehicle speed in km/h, time in seconds). Output channel out_valid/out_ready/
// out_data returns exactly one result per request: alarm and pre-warning flags,
// announcement strobes, the announced limit and the speeding report fields.
// out_valid rises once the result reaches the output register: the sample is
// captured in an input register, evaluated combinationally against the alarm
// state, and the result lands in the output register while the state updates.
// Throughput is one request per cycle while the receiver does not stall; the
// state loop (timers and flags) closes through compare-and-subtract logic.
// When the receiver stalls, the result holds in the output register and one
// more request can still be taken into the input register; in_ready drops
// only when both registers are full.
// The APB port writes the six configuration registers at 4-byte spacing;
// pready is tied high. Derived limits update in the cycle after a write.
// Reset (rst_n low, asynchronous) empties both registers, clears the timers
// and flags and loads the configuration defaults.
`default_nettype none

module overspeed_alarm_monitor
    import osam_pkg::*;
#(
    parameter int unsigned RELEASE_SECONDS = 2
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire sample_t           in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output result_t                out_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    cfg_t    cfg;
    sample_t smp_reg;
    logic    smp_valid_reg;
    result_t res_reg;
    logic    res_valid_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t res_next;
    logic    advance;

    assign pready = 1'b1;

    osam_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    osam_step #(
        .RELEASE_SECONDS (RELEASE_SECONDS)
    ) u_step (
        .cfg (cfg),
        .smp (smp_reg),
        .cur (state_reg),
        .nxt (state_next),
        .res (res_next)
    );

    // Output register free, or being drained this cycle
    assign advance  = !res_valid_reg || out_ready;
    assign in_ready = !smp_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smp_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                smp_valid_reg <= in_valid;
            end
            if (advance)
            begin
                res_valid_reg <= smp_valid_reg;
            end
            // state commits only when the sample moves into the result stage
            if (smp_valid_reg && advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            smp_reg <= in_data;
        end
        if (smp_valid_reg && advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = res_valid_reg;
    assign out_data  = res_reg;

endmodule

`default_nettype wire

FILE: src/osam_cfg.sv
`default_nettype none

module osam_cfg
    import osam_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output cfg_t                   cfg
);

    logic [7:0]  speed_limit_reg;
    logic [15:0] time_threshold_reg;
    logic [15:0] early_warn_delta_reg;
    logic [15:0] report_interval_reg;
    logic [7:0]  area_type_reg;
    logic [31:0] area_id_reg;
    logic [15:0] margin_reg;
    logic [15:0] margin_next;
    logic [6:0]  ann_level_reg;
    logic [6:0]  ann_level_next;
    logic [4:0]  lim_tens;
    logic [7:0]  lim_round;
    logic        wr_en;
    reg_idx_t    idx;

    assign wr_en = psel & penable & pwrite;
    assign idx   = reg_idx_t'(paddr[ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_limit_reg      <= SPEED_LIMIT_RST;
            time_threshold_reg   <= TIME_THRESHOLD_RST;
            early_warn_delta_reg <= EARLY_WARN_DELTA_RST;
            report_interval_reg  <= REPORT_INTERVAL_RST;
            area_type_reg        <= AREA_TYPE_RST;
            area_id_reg          <= AREA_ID_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_SPEED_LIMIT:      speed_limit_reg      <= pwdata[7:0];
                REG_TIME_THRESHOLD:   time_threshold_reg   <= pwdata[15:0];
                REG_EARLY_WARN_DELTA: early_warn_delta_reg <= pwdata[15:0];
                REG_REPORT_INTERVAL:  report_interval_reg  <= pwdata[15:0];
                REG_AREA_TYPE:        area_type_reg        <= pwdata[7:0];
                REG_AREA_ID:          area_id_reg          <= pwdata;
                default:              ;
            endcase
        end
    end

    // Derived values, registered so the multiplies stay off the sample path
    always_comb
    begin
        margin_next = 16'(({16'd0, early_warn_delta_reg} * DIV10_MUL_16) >> DIV10_SHIFT_16);
        lim_tens    = 5'(({8'd0, speed_limit_reg} * DIV10_MUL_8) >> DIV10_SHIFT_8);
        lim_round   = 8'({3'd0, lim_tens} * 8'd10);
        if (lim_round < {1'b0, ANN_LEVEL_MIN})
        begin
            ann_level_next = ANN_LEVEL_MIN;
        end
        else if (lim_round > {1'b0, ANN_LEVEL_MAX})
        begin
            ann_level_next = ANN_LEVEL_MAX;
        end
        else
        begin
            ann_level_next = lim_round[6:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            margin_reg    <= 16'd10;
            ann_level_reg <= ANN_LEVEL_MIN;
        end
        else
        begin
            margin_reg    <= margin_next;
            ann_level_reg <= ann_level_next;
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_SPEED_LIMIT:      prdata = {24'd0, speed_limit_reg};
            REG_TIME_THRESHOLD:   prdata = {16'd0, time_threshold_reg};
            REG_EARLY_WARN_DELTA: prdata = {16'd0, early_warn_delta_reg};
            REG_REPORT_INTERVAL:  prdata = {16'd0, report_interval_reg};
            REG_AREA_TYPE:        prdata = {24'd0, area_type_reg};
            REG_AREA_ID:          prdata = area_id_reg;
            default:              prdata = '0;
        endcase
    end

    always_comb
    begin
        cfg.speed_limit     = speed_limit_reg;
        cfg.time_threshold  = time_threshold_reg;
        cfg.report_interval = report_interval_reg;
        cfg.area_type       = area_type_reg;
        cfg.area_id         = area_id_reg;
        // pre-warning level saturates at zero
        if ({8'd0, speed_limit_reg} > margin_reg)
        begin
            cfg.prewarn_level = speed_limit_reg - margin_reg[7:0];
        end
        else
        begin
            cfg.prewarn_level = 8'd0;
        end
        cfg.ann_level = ann_level_reg;
    end

endmodule

`default_nettype wire

FILE: src/osam_step.sv
`default_nettype none

module osam_step
    import osam_pkg::*;
#(
    parameter int unsigned RELEASE_SECONDS = 2
)
(
    input  wire cfg_t    cfg,
    input  wire sample_t smp,
    input  wire state_t  cur,
    output state_t       nxt,
    output result_t      res
);

    logic        over;
    logic [31:0] since_over;
    logic [31:0] since_release;
    logic [31:0] since_report;
    logic        release_done;
    logic        ann_over;
    logic        ann_pre;
    logic        rep;

    assign over          = smp.vehicle_speed > cfg.speed_limit;
    assign since_over    = smp.now_seconds - cur.over_start_time;
    assign since_release = smp.now_seconds - cur.release_start_time;
    assign since_report  = smp.now_seconds - cur.last_report_time;
    assign release_done  = since_release >= 32'(RELEASE_SECONDS);

    always_comb
    begin
        nxt      = cur;
        ann_over = 1'b0;
        ann_pre  = 1'b0;
        rep      = 1'b0;

        if (over)
        begin
            if (!cur.over_start_valid)
            begin
                nxt.over_start_time  = smp.now_seconds;
                nxt.over_start_valid = 1'b1;
            end
            else
            begin
                if (cur.release_start_valid && release_done)
                begin
                    nxt.release_start_valid = 1'b0;
                end
                if (since_over >= {16'd0, cfg.time_threshold})
                begin
                    ann_over = !cur.alarm_flag ||
                               ((cfg.report_interval != 16'd0) &&
                                (since_report >= {16'd0, cfg.report_interval}));
                    if (ann_over)
                    begin
                        nxt.last_report_time = smp.now_seconds;
                    end
                    nxt.alarm_flag = 1'b1;
                    rep            = 1'b1;
                end
            end
        end
        else
        begin
            if (!cur.release_start_valid)
            begin
                nxt.release_start_time  = smp.now_seconds;
                nxt.release_start_valid = 1'b1;
            end
            else if (release_done)
            begin
                nxt.over_start_valid = 1'b0;
                nxt.alarm_flag       = 1'b0;
            end
        end

        // pre-warning held low while the alarm is up
        if (nxt.alarm_flag)
        begin
            nxt.prewarn_flag = 1'b0;
        end
        else if (smp.vehicle_speed > cfg.prewarn_level)
        begin
            ann_pre          = !cur.prewarn_flag;
            nxt.prewarn_flag = 1'b1;
        end
        else
        begin
            nxt.prewarn_flag = 1'b0;
        end

        res.overspeed_alarm    = nxt.alarm_flag;
        res.prewarn_alarm      = nxt.prewarn_flag;
        res.announce_overspeed = ann_over;
        res.announce_prewarn   = ann_pre;
        res.announced_limit    = cfg.ann_level;
        res.report_valid       = rep;
        res.report_area_type   = rep ? cfg.area_type : 8'd0;
        res.report_area_id     = (rep && (cfg.area_type != 8'd0)) ? cfg.area_id : 32'd0;
    end

endmodule

`default_nettype wire
